[rtl/core/lcg63_pkg.sv]
// shared types and constants for the 63-bit lcg with skip-ahead
`timescale 1ns / 1ps

package lcg63_pkg;

    localparam int STATE_W = 63;
    localparam int OP_W    = 2;

    localparam logic [STATE_W-1:0] LCG_MULT = 63'd2806196910506780709;
    localparam logic [STATE_W-1:0] LCG_INC  = 63'd1;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_LOAD = 2'd0;
    localparam t_op OP_NEXT = 2'd1;
    localparam t_op OP_SKIP = 2'd2;

    // which product the shared multiplier is working on
    typedef logic [1:0] t_sel;

    localparam t_sel SEL_NEXT = 2'd0;
    localparam t_sel SEL_X    = 2'd1;
    localparam t_sel SEL_AP   = 2'd2;
    localparam t_sel SEL_MP   = 2'd3;

    typedef struct packed {
        logic load_seed;
        logic init_skip;
        logic mul_go;
        t_sel mul_sel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic n_zero;
        logic n_bit0;
        logic n_last;
    } t_stat;

endpackage

[rtl/core/lcg63_with_skip_ahead.sv]
// top level of the 63-bit lcg with load, step and skip-ahead
//
//  channel  | signals                       | transfer
//  ---------+-------------------------------+------------------------------
//  command  | start, busy, i_op, i_value    | edge with start high, busy low
//  result   | o_done, o_state_out           | edge ending the o_done cycle
//
// load and unused op codes: result strobe in the cycle after the transfer;
//   busy only while the strobe is high, then idle for the next command
// next step: one pass through the 4-phase 32x32 multiplier, then the result
//   strobe; busy until the strobe ends, so no new command overlaps a step
// skip by n: per bit of n a check in S_CHK, then 2 multiplies if the bit is
//   clear, else 3 (1 on the top bit), all on the single shared multiplier
// synchronous active-low reset puts the state at 1; no clearing pass
// the receiver cannot stall; each result is shown for one cycle only
`timescale 1ns / 1ps

module lcg63_with_skip_ahead (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lcg63_pkg::OP_W-1:0]    i_op,
    input  logic [lcg63_pkg::STATE_W-1:0] i_value,
    output logic                          o_done,
    output logic [lcg63_pkg::STATE_W-1:0] o_state_out
);
    import lcg63_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lcg63_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    lcg63_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_value),
        .o_stat  (stat),
        .o_state (o_state_out)
    );

endmodule

[rtl/core/lcg63_mul.sv]
// multi-cycle 63x63 multiply-add mod 2^63 on one 32x32 multiplier
`timescale 1ns / 1ps

module lcg63_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [lcg63_pkg::STATE_W-1:0] i_a,
    input  logic [lcg63_pkg::STATE_W-1:0] i_b,
    input  logic [lcg63_pkg::STATE_W-1:0] i_c,
    output logic                          o_done,
    output logic [lcg63_pkg::STATE_W-1:0] o_res
);
    import lcg63_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LL   = 3'd1;
    localparam logic [2:0] PH_LH   = 3'd2;
    localparam logic [2:0] PH_HL   = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [2:0]         r_ph, n_ph;
    logic               r_done;
    logic [STATE_W-1:0] r_a, r_b, r_c, r_acc, r_res;
    logic [63:0]        r_prod;
    logic [31:0]        ma, mb;
    logic [63:0]        prod;
    logic [STATE_W-1:0] prod_hi;

    always_comb begin
        case (r_ph)
            PH_LL: begin
                ma = r_a[31:0];
                mb = r_b[31:0];
            end
            PH_LH: begin
                ma = r_a[31:0];
                mb = {1'b0, r_b[62:32]};
            end
            PH_HL: begin
                ma = {1'b0, r_a[62:32]};
                mb = r_b[31:0];
            end
            default: begin
                ma = 32'd0;
                mb = 32'd0;
            end
        endcase
    end

    assign prod    = ma * mb;
    // cross products only land in the upper 31 bits of the result
    assign prod_hi = {r_prod[30:0], 32'd0};

    always_comb begin
        case (r_ph)
            PH_IDLE: n_ph = i_go ? PH_LL : PH_IDLE;
            PH_LL:   n_ph = PH_LH;
            PH_LH:   n_ph = PH_HL;
            PH_HL:   n_ph = PH_SUM;
            default: n_ph = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= (r_ph == PH_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && r_ph == PH_IDLE) begin
            r_a <= i_a;
            r_b <= i_b;
            r_c <= i_c;
        end
        r_prod <= prod;
        case (r_ph)
            PH_LH:   r_acc <= r_prod[STATE_W-1:0];
            PH_HL:   r_acc <= r_acc + prod_hi;
            PH_SUM:  r_res <= r_acc + prod_hi + r_c;
            default: r_acc <= r_acc;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> r_ph == PH_IDLE)
        else $error("multiply started while busy");

    a_go_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |=> r_ph == PH_LL)
        else $error("multiply did not start");

    a_done_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == PH_SUM |=> o_done)
        else $error("multiply finish not flagged");

endmodule

[rtl/core/lcg63_dp.sv]
// datapath: generator state, skip-ahead powers, step count and multiplier
`timescale 1ns / 1ps

module lcg63_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcg63_pkg::t_cmd               i_cmd,
    input  logic [lcg63_pkg::STATE_W-1:0] i_value,
    output lcg63_pkg::t_stat              o_stat,
    output logic [lcg63_pkg::STATE_W-1:0] o_state
);
    import lcg63_pkg::*;

    logic [STATE_W-1:0] r_x, r_mp, r_ap, r_n;
    t_sel               r_sel;
    logic [STATE_W-1:0] ma, mb, mc, mres;
    logic               mdone;

    // operands for the product being issued
    always_comb begin
        case (i_cmd.mul_sel)
            SEL_NEXT: begin
                ma = LCG_MULT;
                mb = r_x;
                mc = LCG_INC;
            end
            SEL_X: begin
                ma = r_mp;
                mb = r_x;
                mc = r_ap;
            end
            SEL_AP: begin
                ma = r_ap;
                mb = r_mp + LCG_INC;
                mc = '0;
            end
            default: begin
                ma = r_mp;
                mb = r_mp;
                mc = '0;
            end
        endcase
    end

    lcg63_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (ma),
        .i_b     (mb),
        .i_c     (mc),
        .o_done  (mdone),
        .o_res   (mres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= LCG_INC;
        end else if (i_cmd.load_seed) begin
            r_x <= i_value;
        end else if (mdone && (r_sel == SEL_NEXT || r_sel == SEL_X)) begin
            r_x <= mres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_sel <= i_cmd.mul_sel;
        end
        if (i_cmd.init_skip) begin
            r_mp <= LCG_MULT;
            r_ap <= LCG_INC;
            r_n  <= i_value;
        end else if (mdone) begin
            case (r_sel)
                SEL_AP: r_ap <= mres;
                SEL_MP: begin
                    r_mp <= mres;
                    r_n  <= {1'b0, r_n[STATE_W-1:1]};
                end
                default: r_ap <= r_ap;
            endcase
        end
    end

    assign o_stat.mul_done = mdone;
    assign o_stat.n_zero   = (r_n == '0);
    assign o_stat.n_bit0   = r_n[0];
    assign o_stat.n_last   = (r_n[STATE_W-1:1] == '0);
    assign o_state         = r_x;

endmodule

[rtl/core/lcg63_ctrl.sv]
// controller: sequences load, single step and square-and-multiply skip
`timescale 1ns / 1ps

module lcg63_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lcg63_pkg::t_op   i_op,
    input  lcg63_pkg::t_stat i_stat,
    output lcg63_pkg::t_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import lcg63_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEXT = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_X    = 3'd3;
    localparam logic [2:0] S_AP   = 3'd4;
    localparam logic [2:0] S_MP   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = SEL_NEXT;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        OP_LOAD: begin
                            o_cmd.load_seed = 1'b1;
                            n_state = S_DONE;
                        end
                        OP_NEXT: begin
                            o_cmd.mul_go = 1'b1;
                            n_state = S_NEXT;
                        end
                        OP_SKIP: begin
                            o_cmd.init_skip = 1'b1;
                            n_state = S_CHK;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_NEXT: begin
                if (i_stat.mul_done) begin
                    n_state = S_DONE;
                end
            end
            S_CHK: begin
                // one bit of the step count per pass
                if (i_stat.n_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.n_bit0) begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = SEL_X;
                    n_state = S_X;
                end else begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = SEL_AP;
                    n_state = S_AP;
                end
            end
            S_X: begin
                if (i_stat.mul_done) begin
                    if (i_stat.n_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = SEL_AP;
                        n_state = S_AP;
                    end
                end
            end
            S_AP: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = SEL_MP;
                    n_state = S_MP;
                end
            end
            S_MP: begin
                if (i_stat.mul_done) begin
                    n_state = S_CHK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy)
        else $error("result strobe longer than one cycle");

    a_go_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_go |=> !o_cmd.mul_go)
        else $error("back-to-back multiply issue");

endmodule
